@@ rtl/kmrt_pkg.sv @@
// Shared types and codes for the kernel map region table.
// Used by kmrt_store, kernel_map_region_table and kmrt_checker; depends on nothing.

package kmrt_pkg;

   // Field widths of one word on the request and response channels.
   localparam int ADDR_W = 32;
   localparam int LEN_W  = 32;
   localparam int ATTR_W = 12;
   localparam int SLOT_W = 4;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_LIST   = 2'd3
   } kmrt_cmd_type;

   // Response status codes.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_EMPTY     = 3'd4
   } kmrt_status_type;

   // One stored region.
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
      logic [ATTR_W-1:0] attributes;
   } kmrt_entry_type;

   // Control strobes from the sequencer to the region store.
   typedef struct packed {
      logic rd_en;  // read the entry at the scan index
      logic wr_en;  // write an entry and mark it occupied
      logic drop;   // mark the entry at the scan index free
      logic wipe;   // mark every entry free
   } kmrt_store_ctl_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DUP_READ,
      S_DUP_CHECK,
      S_FREE_SEARCH,
      S_REM_READ,
      S_REM_CHECK,
      S_LIST_READ,
      S_LIST_CHECK,
      S_REPLY
   } kmrt_state_type;

endpackage

@@ rtl/kmrt_store.sv @@
// Region store: a single-port-read table of region entries plus occupancy bits.
// Depends on kmrt_pkg for the entry and control types.

module kmrt_store import kmrt_pkg::*; #(
   parameter int ENTRIES = 16,
   localparam int IDX_W = $clog2(ENTRIES)
) (
   input  logic               clock,
   input  logic               reset,
   input  kmrt_store_ctl_type ctl,
   input  logic [IDX_W-1:0]   rd_addr,
   input  logic [IDX_W-1:0]   wr_addr,
   input  kmrt_entry_type     wr_entry,
   output kmrt_entry_type     rd_entry,
   output logic [ENTRIES-1:0] valid
);

   kmrt_entry_type     mem [ENTRIES];
   kmrt_entry_type     rd_entry_ff;
   logic [ENTRIES-1:0] valid_ff;

   // Entry contents; a free entry is never read for its payload.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   // Occupancy bits; a free entry stands for an all-zero region.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wipe) begin
         valid_ff <= '0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.drop) begin
            valid_ff[rd_addr] <= 1'b0;
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign valid    = valid_ff;

endmodule

@@ rtl/kernel_map_region_table.sv @@
// Kernel map region table: top level with the command sequencer and response register.
// Depends on kmrt_pkg and kmrt_store.

// The table holds TABLE_ENTRIES regions and handles one command at a time; req_stall is
// high from the cycle after a word is accepted until the command's sequencer has finished.
// All work goes through one comparator set that visits one slot per step, fed by the
// store's single registered read port: an occupied slot takes a read state and a check
// state, a free slot the read state alone. Clear wipes the table at the accepting edge
// and then replies. Remove scans the slots in index order. Insert first scans the slots
// for a duplicate and then makes a circular free-slot search from the rotating pointer.
// List walks the slots in index order up to the last occupied one; an empty list scans
// every slot. Every command also waits while rsp_stall holds a response word. The table
// comes out of reset empty with no clearing pass.

module kernel_map_region_table import kmrt_pkg::*; #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [ADDR_W-1:0] req_start_address,
   input  logic [LEN_W-1:0]  req_length,
   input  logic [ATTR_W-1:0] req_attributes,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot_index,
   output logic [ADDR_W-1:0] rsp_out_start,
   output logic [LEN_W-1:0]  rsp_out_length,
   output logic [ATTR_W-1:0] rsp_out_attributes,
   output logic              rsp_is_io,
   output logic              rsp_last,
   // configuration
   input  logic              csr_write_enable,
   input  logic [ADDR_W-1:0] csr_write_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [TABLE_ENTRIES-1:0] ONE = TABLE_ENTRIES'(1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   // sequencer state
   kmrt_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [ADDR_W-1:0] key_start_ff, key_start_in;
   logic [LEN_W-1:0]  key_length_ff, key_length_in;
   logic [ATTR_W-1:0] key_attr_ff, key_attr_in;
   kmrt_status_type   reply_status_ff, reply_status_in;
   logic [SLOT_W-1:0] reply_slot_ff, reply_slot_in;
   logic [ADDR_W-1:0] memsize_ff;

   // response register
   logic              rsp_valid_ff;
   kmrt_status_type   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0] rsp_start_ff, rsp_start_in;
   logic [LEN_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic              rsp_io_ff, rsp_io_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              load_rsp;

   // store connection
   kmrt_store_ctl_type       ctl;
   kmrt_entry_type           wr_entry;
   kmrt_entry_type           rd_entry;
   logic [TABLE_ENTRIES-1:0] valid;

   logic [IDX_W-1:0]         idx;
   logic                     scan_done;
   logic                     out_free;
   logic [TABLE_ENTRIES-1:0] upto_mask;
   logic                     more_after;

   kmrt_store #(.ENTRIES(TABLE_ENTRIES)) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_addr  (idx),
      .wr_addr  (scan_ff),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry),
      .valid    (valid)
   );

   // Scan position and the occupied slots past it, for the final list word.
   assign idx        = cnt_ff[IDX_W-1:0];
   assign scan_done  = (cnt_ff == CNT_W'(TABLE_ENTRIES));
   assign upto_mask  = ((ONE << idx) << 1) - ONE;
   assign more_after = |(valid & ~upto_mask);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);

   assign wr_entry.start      = key_start_ff;
   assign wr_entry.length     = key_length_ff;
   assign wr_entry.attributes = key_attr_ff;

   // Next state and control for the sequencer.
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      scan_in         = scan_ff;
      ptr_in          = ptr_ff;
      key_start_in    = key_start_ff;
      key_length_in   = key_length_ff;
      key_attr_in     = key_attr_ff;
      reply_status_in = reply_status_ff;
      reply_slot_in   = reply_slot_ff;
      ctl             = '0;
      load_rsp        = 1'b0;
      rsp_status_in   = STATUS_OK;
      rsp_slot_in     = '0;
      rsp_start_in    = '0;
      rsp_length_in   = '0;
      rsp_attr_in     = '0;
      rsp_io_in       = 1'b0;
      rsp_last_in     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_start_in  = req_start_address;
               key_length_in = req_length;
               key_attr_in   = req_attributes;
               cnt_in        = '0;
               unique case (kmrt_cmd_type'(req_command))
                  CMD_INSERT: state_in = S_DUP_READ;
                  CMD_REMOVE: state_in = S_REM_READ;
                  CMD_CLEAR: begin
                     ctl.wipe        = 1'b1;
                     reply_status_in = STATUS_OK;
                     reply_slot_in   = '0;
                     state_in        = S_REPLY;
                  end
                  CMD_LIST: state_in = S_LIST_READ;
               endcase
            end
         end

         // A free slot reads as a zero start, so it matches only a zero key.
         S_DUP_READ: begin
            if (scan_done) begin
               cnt_in   = '0;
               scan_in  = ptr_ff;
               state_in = S_FREE_SEARCH;
            end else if (valid[idx]) begin
               ctl.rd_en = 1'b1;
               state_in  = S_DUP_CHECK;
            end else if (key_start_ff == '0) begin
               reply_status_in = STATUS_DUPLICATE;
               reply_slot_in   = '0;
               state_in        = S_REPLY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_DUP_CHECK: begin
            if (rd_entry.start == key_start_ff) begin
               reply_status_in = STATUS_DUPLICATE;
               reply_slot_in   = '0;
               state_in        = S_REPLY;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_DUP_READ;
            end
         end

         // Circular search for a free slot from the rotating pointer.
         S_FREE_SEARCH: begin
            if (scan_done) begin
               reply_status_in = STATUS_FULL;
               reply_slot_in   = '0;
               state_in        = S_REPLY;
            end else if (!valid[scan_ff]) begin
               ctl.wr_en       = 1'b1;
               ptr_in          = wrap_inc(scan_ff);
               reply_status_in = STATUS_OK;
               reply_slot_in   = SLOT_W'(scan_ff);
               state_in        = S_REPLY;
            end else begin
               scan_in = wrap_inc(scan_ff);
               cnt_in  = cnt_ff + 1'b1;
            end
         end

         // A free slot is an all-zero region and may match a zero start and length.
         S_REM_READ: begin
            if (scan_done) begin
               reply_status_in = STATUS_NOT_FOUND;
               reply_slot_in   = '0;
               state_in        = S_REPLY;
            end else if (valid[idx]) begin
               ctl.rd_en = 1'b1;
               state_in  = S_REM_CHECK;
            end else if ((key_start_ff == '0) && (key_length_ff == '0)) begin
               reply_status_in = STATUS_OK;
               reply_slot_in   = SLOT_W'(idx);
               state_in        = S_REPLY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_REM_CHECK: begin
            if ((rd_entry.start == key_start_ff) && (rd_entry.length == key_length_ff)) begin
               ctl.drop        = 1'b1;
               reply_status_in = STATUS_OK;
               reply_slot_in   = SLOT_W'(idx);
               state_in        = S_REPLY;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_REM_READ;
            end
         end

         // Walk the slots in index order, reading only the occupied ones.
         S_LIST_READ: begin
            if (scan_done) begin
               reply_status_in = STATUS_EMPTY;
               reply_slot_in   = '0;
               state_in        = S_REPLY;
            end else if (valid[idx]) begin
               ctl.rd_en = 1'b1;
               state_in  = S_LIST_CHECK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_LIST_CHECK: begin
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = SLOT_W'(idx);
               rsp_start_in  = rd_entry.start;
               rsp_length_in = rd_entry.length;
               rsp_attr_in   = rd_entry.attributes;
               rsp_io_in     = (rd_entry.start >= memsize_ff);
               rsp_last_in   = !more_after;
               cnt_in        = cnt_ff + 1'b1;
               state_in      = more_after ? S_LIST_READ : S_IDLE;
            end
         end

         // Single-word result of insert, remove, clear or an empty list.
         S_REPLY: begin
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_status_in = reply_status_ff;
               rsp_slot_in   = reply_slot_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         scan_ff  <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         scan_ff  <= scan_in;
         ptr_ff   <= ptr_in;
      end
   end

   // Request key and pending reply.
   always_ff @(posedge clock) begin
      key_start_ff    <= key_start_in;
      key_length_ff   <= key_length_in;
      key_attr_ff     <= key_attr_in;
      reply_status_ff <= reply_status_in;
      reply_slot_ff   <= reply_slot_in;
   end

   // Memory size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         memsize_ff <= '0;
      end else if (csr_write_enable) begin
         memsize_ff <= csr_write_data;
      end
   end

   // Response register; it holds its word while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_start_ff  <= rsp_start_in;
         rsp_length_ff <= rsp_length_in;
         rsp_attr_ff   <= rsp_attr_in;
         rsp_io_ff     <= rsp_io_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_out_start      = rsp_start_ff;
   assign rsp_out_length     = rsp_length_ff;
   assign rsp_out_attributes = rsp_attr_ff;
   assign rsp_is_io          = rsp_io_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

@@ rtl/kmrt_checker.sv @@
// Port-level checks for the kernel map region table, bound to the top level.
// Depends on kmrt_pkg for the status codes and on kernel_map_region_table.

module kmrt_checker import kmrt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_status,
   input logic [SLOT_W-1:0] rsp_slot_index,
   input logic [ADDR_W-1:0] rsp_out_start,
   input logic [LEN_W-1:0]  rsp_out_length,
   input logic [ATTR_W-1:0] rsp_out_attributes,
   input logic              rsp_is_io,
   input logic              rsp_last
);

   // Every accepted command keeps the block busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but block not busy next cycle");

   // A stalled response word stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot_index) && $stable(rsp_out_start)
         && $stable(rsp_out_length) && $stable(rsp_out_attributes)
         && $stable(rsp_is_io) && $stable(rsp_last)))
      else $error("stalled response word changed");

   // Error and empty-list results are always the only word of their command.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> rsp_last)
      else $error("non-ok status without last");

   // A word that is not the last comes from a listing and shows an occupied slot.
   a_list_word_occupied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> ((rsp_status == STATUS_OK) && (rsp_out_start != '0)))
      else $error("intermediate list word shows a free slot");

endmodule

bind kernel_map_region_table kmrt_checker u_kmrt_checker (.*);
